// File: src/log_line_field_parser_top_macros.svh
// Assertion macros for the checker file of the log line field parser.
`ifndef LOG_LINE_FIELD_PARSER_TOP_MACROS_SVH
`define LOG_LINE_FIELD_PARSER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define LLFP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define LLFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/llfp_pkg.sv
// Shared types, constants and character codes of the log line field parser.
package llfp_pkg;

  localparam int unsigned LINE_MAX_DEF = 512;
  localparam int unsigned TAG_MAX_DEF  = 48;
  localparam int unsigned MSG_MAX_DEF  = 384;

  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 80;

  localparam logic [7:0] CH_E      = 8'h45;
  localparam logic [7:0] CH_W      = 8'h57;
  localparam logic [7:0] CH_I      = 8'h49;
  localparam logic [7:0] CH_D      = 8'h44;
  localparam logic [7:0] CH_V      = 8'h56;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_NUL    = 8'h00;

  localparam int unsigned MIN_HEADER_LEN = 6;

  localparam logic [1:0] DEPTH_RAW   = 2'd0;
  localparam logic [1:0] DEPTH_LEVEL = 2'd1;
  localparam logic [1:0] DEPTH_TIME  = 2'd2;
  localparam logic [1:0] DEPTH_FULL  = 2'd3;

  typedef enum logic [1:0] {
    NUM_SKIP   = 2'd0,
    NUM_SIGN   = 2'd1,
    NUM_DIGITS = 2'd2,
    NUM_DONE   = 2'd3
  } num_phase_e;

  // Fixed-width part of the running line state, as seen after the current item.
  typedef struct packed {
    logic [7:0]  first_char;
    logic        header_ok;
    logic        paren_found;
    logic        colon_found;
    logic        num_neg;
    logic        num_ovf;
    logic [31:0] num_value;
  } scan_flags_t;

  typedef struct packed {
    logic [8:0]  msg_length;
    logic [8:0]  msg_offset;
    logic [5:0]  tag_length;
    logic [8:0]  tag_offset;
    logic [31:0] timestamp_ms;
    logic [1:0]  parse_depth;
    logic [7:0]  level_char;
  } desc_t;

endpackage

// File: src/llfp_scan.sv
// Running line state: header check, timestamp accumulator, delimiter and CR/LF tracking.
module llfp_scan #(
  parameter int unsigned LINE_MAX = llfp_pkg::LINE_MAX_DEF,
  parameter int unsigned MSG_MAX  = llfp_pkg::MSG_MAX_DEF,
  localparam int unsigned PW = $clog2(LINE_MAX)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic [7:0]            byte_i,
  input  logic                  last_i,
  output llfp_pkg::scan_flags_t flags_o,
  output logic [PW-1:0]         pos_o,
  output logic [PW-1:0]         paren_o,
  output logic [PW-1:0]         colon_o,
  output logic [PW-1:0]         crlf_o,
  output logic [PW-1:0]         clip_o
);

  localparam logic [PW-1:0] POS_LIMIT = PW'(LINE_MAX - 1);
  localparam int unsigned   CW        = PW + 2;

  logic [PW-1:0]         pos_q, pos_d;
  logic                  ended_q, ended_d;
  logic [7:0]            prev_q, prev_d;
  logic [PW-1:0]         paren_q, paren_d;
  logic [PW-1:0]         colon_q, colon_d;
  logic [PW-1:0]         crlf_q, crlf_d;
  logic [PW-1:0]         clip_q, clip_d;
  llfp_pkg::scan_flags_t flags_q, flags_d;
  llfp_pkg::num_phase_e  phase_q, phase_d;

  logic       take;
  logic       num_en;
  logic       is_digit;
  logic       is_space;
  logic [3:0] digit;
  logic [35:0] num_next;

  assign take     = !ended_q && (byte_i != llfp_pkg::CH_NUL) && (pos_q < POS_LIMIT);
  assign num_en   = take && (pos_q >= PW'(3));
  assign is_digit = (byte_i >= llfp_pkg::CH_ZERO) && (byte_i <= llfp_pkg::CH_NINE);
  assign is_space = byte_i inside {llfp_pkg::CH_SPACE, [llfp_pkg::CH_TAB:llfp_pkg::CH_CR]};
  assign digit    = 4'(byte_i - llfp_pkg::CH_ZERO);
  assign num_next = 36'(flags_q.num_value) * 36'd10 + 36'(digit);

  // Number phase: skip whitespace, take a sign, collect digits, then stop.
  always_comb begin
    phase_d = phase_q;
    if (num_en) begin
      case (phase_q)
        llfp_pkg::NUM_SKIP: begin
          if (is_space) phase_d = llfp_pkg::NUM_SKIP;
          else if (byte_i == llfp_pkg::CH_PLUS || byte_i == llfp_pkg::CH_MINUS)
            phase_d = llfp_pkg::NUM_SIGN;
          else if (is_digit) phase_d = llfp_pkg::NUM_DIGITS;
          else phase_d = llfp_pkg::NUM_DONE;
        end
        llfp_pkg::NUM_SIGN: begin
          phase_d = is_digit ? llfp_pkg::NUM_DIGITS : llfp_pkg::NUM_DONE;
        end
        llfp_pkg::NUM_DIGITS: begin
          if (!is_digit) phase_d = llfp_pkg::NUM_DONE;
        end
        default: phase_d = phase_q;
      endcase
    end
  end

  // Line state and accumulator updates for the current item.
  always_comb begin
    flags_d = flags_q;
    pos_d   = pos_q;
    ended_d = ended_q;
    prev_d  = prev_q;
    paren_d = paren_q;
    colon_d = colon_q;
    crlf_d  = crlf_q;
    clip_d  = clip_q;
    if (!ended_q && byte_i == llfp_pkg::CH_NUL) ended_d = 1'b1;
    if (take) begin
      if (pos_q == PW'(0)) flags_d.first_char = byte_i;
      else if (pos_q == PW'(1)) flags_d.header_ok = (byte_i == llfp_pkg::CH_SPACE);
      else if (pos_q == PW'(2))
        flags_d.header_ok = flags_q.header_ok && (byte_i == llfp_pkg::CH_LPAREN);

      if (pos_q >= PW'(4) && !flags_q.paren_found && prev_q == llfp_pkg::CH_RPAREN &&
          byte_i == llfp_pkg::CH_SPACE) begin
        flags_d.paren_found = 1'b1;
        paren_d = pos_q - PW'(1);
      end else if (flags_q.paren_found && !flags_q.colon_found &&
                   prev_q == llfp_pkg::CH_COLON && byte_i == llfp_pkg::CH_SPACE &&
                   (CW'(pos_q) - CW'(1)) >= (CW'(paren_q) + CW'(2))) begin
        flags_d.colon_found = 1'b1;
        colon_d = pos_q - PW'(1);
      end

      crlf_d = (byte_i == llfp_pkg::CH_CR || byte_i == llfp_pkg::CH_LF) ?
               crlf_q + PW'(1) : PW'(0);
      if (32'(pos_q) == 32'(MSG_MAX - 2)) clip_d = crlf_d;
      prev_d = byte_i;
      pos_d  = pos_q + PW'(1);
    end
    if (num_en) begin
      case (phase_q)
        llfp_pkg::NUM_SKIP: begin
          if (!is_space) begin
            if (byte_i == llfp_pkg::CH_MINUS) flags_d.num_neg = 1'b1;
            else if (byte_i != llfp_pkg::CH_PLUS && is_digit) flags_d.num_value = 32'(digit);
          end
        end
        llfp_pkg::NUM_SIGN: begin
          if (is_digit) flags_d.num_value = 32'(digit);
        end
        llfp_pkg::NUM_DIGITS: begin
          if (is_digit && !flags_q.num_ovf) begin
            if (num_next[35:32] != 4'd0) flags_d.num_ovf = 1'b1;
            else flags_d.num_value = num_next[31:0];
          end
        end
        default: flags_d = flags_d;
      endcase
    end
  end

  // Clear everything after the last item of a line.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
      phase_q <= llfp_pkg::NUM_SKIP;
      pos_q   <= '0;
      ended_q <= 1'b0;
      prev_q  <= '0;
      paren_q <= '0;
      colon_q <= '0;
      crlf_q  <= '0;
      clip_q  <= '0;
    end else if (step_i) begin
      if (last_i) begin
        flags_q <= '0;
        phase_q <= llfp_pkg::NUM_SKIP;
        pos_q   <= '0;
        ended_q <= 1'b0;
        prev_q  <= '0;
        paren_q <= '0;
        colon_q <= '0;
        crlf_q  <= '0;
        clip_q  <= '0;
      end else begin
        flags_q <= flags_d;
        phase_q <= phase_d;
        pos_q   <= pos_d;
        ended_q <= ended_d;
        prev_q  <= prev_d;
        paren_q <= paren_d;
        colon_q <= colon_d;
        crlf_q  <= crlf_d;
        clip_q  <= clip_d;
      end
    end
  end

  assign flags_o = flags_d;
  assign pos_o   = pos_d;
  assign paren_o = paren_d;
  assign colon_o = colon_d;
  assign crlf_o  = crlf_d;
  assign clip_o  = clip_d;

endmodule

// File: src/llfp_final.sv
// Descriptor build: parse depth, level, timestamp, tag and message spans.
module llfp_final #(
  parameter int unsigned LINE_MAX = llfp_pkg::LINE_MAX_DEF,
  parameter int unsigned TAG_MAX  = llfp_pkg::TAG_MAX_DEF,
  parameter int unsigned MSG_MAX  = llfp_pkg::MSG_MAX_DEF,
  localparam int unsigned PW = $clog2(LINE_MAX)
) (
  input  llfp_pkg::scan_flags_t flags_i,
  input  logic [PW-1:0]         pos_i,
  input  logic [PW-1:0]         paren_i,
  input  logic [PW-1:0]         colon_i,
  input  logic [PW-1:0]         crlf_i,
  input  logic [PW-1:0]         clip_i,
  output llfp_pkg::desc_t       desc_o
);

  localparam int unsigned MW  = $clog2(MSG_MAX);
  localparam int unsigned TW  = $clog2(TAG_MAX);
  localparam int unsigned MX1 = (PW > MW) ? PW : MW;
  localparam int unsigned MX2 = (MX1 > TW) ? MX1 : TW;
  localparam int unsigned KW  = MX2 + 1;
  localparam logic [KW-1:0] TAG_CLIP = KW'(TAG_MAX - 1);
  localparam logic [KW-1:0] MSG_CLIP = KW'(MSG_MAX - 1);

  logic [KW-1:0] len;
  logic [KW-1:0] tag_off, tag_len, tag_cut;
  logic [KW-1:0] msg_off, full_len, full_strip, full_cut;
  logic [KW-1:0] raw_len, raw_run, raw_strip;
  logic [KW-1:0] msg_len;
  logic          level_ok;
  logic [1:0]    depth;
  logic [31:0]   ts;

  assign len      = KW'(pos_i);
  assign level_ok = flags_i.first_char inside {llfp_pkg::CH_E, llfp_pkg::CH_W,
                    llfp_pkg::CH_I, llfp_pkg::CH_D, llfp_pkg::CH_V};

  always_comb begin
    if (len < KW'(llfp_pkg::MIN_HEADER_LEN) || !flags_i.header_ok || !level_ok)
      depth = llfp_pkg::DEPTH_RAW;
    else if (!flags_i.paren_found) depth = llfp_pkg::DEPTH_LEVEL;
    else if (!flags_i.colon_found) depth = llfp_pkg::DEPTH_TIME;
    else depth = llfp_pkg::DEPTH_FULL;
  end

  always_comb begin
    if (depth == llfp_pkg::DEPTH_RAW || depth == llfp_pkg::DEPTH_LEVEL) ts = '0;
    else if (flags_i.num_ovf) ts = '1;
    else if (flags_i.num_neg) ts = 32'(0) - flags_i.num_value;
    else ts = flags_i.num_value;
  end

  // Full parse: tag between ") " and ": ", message after ": " less trailing CR/LF.
  assign tag_off    = KW'(paren_i) + KW'(2);
  assign tag_len    = KW'(colon_i) - tag_off;
  assign tag_cut    = (tag_len > TAG_CLIP) ? TAG_CLIP : tag_len;
  assign msg_off    = KW'(colon_i) + KW'(2);
  assign full_len   = len - msg_off;
  assign full_strip = full_len - ((KW'(crlf_i) < full_len) ? KW'(crlf_i) : full_len);
  assign full_cut   = (full_strip > MSG_CLIP) ? MSG_CLIP : full_strip;

  // Fallback: whole line, clipped first, then trailing CR/LF of the kept part dropped.
  assign raw_len   = (len <= MSG_CLIP) ? len : MSG_CLIP;
  assign raw_run   = (len <= MSG_CLIP) ? KW'(crlf_i) : KW'(clip_i);
  assign raw_strip = raw_len - ((raw_run > raw_len) ? raw_len : raw_run);

  assign msg_len = (depth == llfp_pkg::DEPTH_FULL) ? full_cut : raw_strip;

  always_comb begin
    desc_o              = '0;
    desc_o.level_char   = (depth == llfp_pkg::DEPTH_RAW) ? llfp_pkg::CH_QMARK
                                                         : flags_i.first_char;
    desc_o.parse_depth  = depth;
    desc_o.timestamp_ms = ts;
    desc_o.msg_length   = 9'(msg_len);
    if (depth == llfp_pkg::DEPTH_FULL) begin
      desc_o.tag_offset = 9'(tag_off);
      desc_o.tag_length = 6'(tag_cut);
      desc_o.msg_offset = 9'(msg_off);
    end
  end

endmodule

// File: src/log_line_field_parser_top.sv
// Top level of the log line field parser: stream ports, input and result registers.
// Parses one log line of the form "L (NNNN) TAG: MSG", one byte per input item, and
// gives one descriptor item for the item that carries tlast. A byte is registered,
// then updates the running line state when it moves on, and the last byte of a line
// loads the descriptor into the result register in that same cycle, so one item per
// clock is sustained while no last byte stalls. The input side stalls only on a last
// byte while the previous descriptor still waits on m_axis_tready. Bytes after a
// zero byte, or past the first LINE_MAX-1, leave the state unchanged.
module log_line_field_parser_top #(
  parameter int unsigned LINE_MAX = llfp_pkg::LINE_MAX_DEF,
  parameter int unsigned TAG_MAX  = llfp_pkg::TAG_MAX_DEF,
  parameter int unsigned MSG_MAX  = llfp_pkg::MSG_MAX_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [7:0] line_byte
  input  logic [llfp_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                             s_axis_tlast,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [7:0] level_char, [9:8] parse_depth, [41:10] timestamp_ms, [50:42] tag_offset,
  // [56:51] tag_length, [65:57] msg_offset, [74:66] msg_length, [79:75] zero
  output logic [llfp_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int unsigned PW = $clog2(LINE_MAX);

  logic            in_v_q;
  logic [7:0]      in_byte_q;
  logic            in_last_q;
  logic            out_v_q, out_v_d;
  llfp_pkg::desc_t out_q;
  llfp_pkg::desc_t desc;

  llfp_pkg::scan_flags_t flags;
  logic [PW-1:0] pos, paren, colon, crlf, clip;

  logic advance;
  logic load;

  // A last byte needs a free result slot; other bytes always move on.
  assign advance       = in_v_q && (!in_last_q || !out_v_q || m_axis_tready);
  assign load          = advance && in_last_q;
  assign s_axis_tready = !in_v_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata[7:0];
      in_last_q <= s_axis_tlast;
    end
  end

  llfp_scan #(
    .LINE_MAX (LINE_MAX),
    .MSG_MAX  (MSG_MAX)
  ) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .byte_i  (in_byte_q),
    .last_i  (in_last_q),
    .flags_o (flags),
    .pos_o   (pos),
    .paren_o (paren),
    .colon_o (colon),
    .crlf_o  (crlf),
    .clip_o  (clip)
  );

  llfp_final #(
    .LINE_MAX (LINE_MAX),
    .TAG_MAX  (TAG_MAX),
    .MSG_MAX  (MSG_MAX)
  ) u_final (
    .flags_i (flags),
    .pos_i   (pos),
    .paren_i (paren),
    .colon_i (colon),
    .crlf_i  (crlf),
    .clip_i  (clip),
    .desc_o  (desc)
  );

  always_comb begin
    out_v_d = out_v_q;
    if (load) out_v_d = 1'b1;
    else if (m_axis_tready) out_v_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) out_q <= desc;
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {5'd0, out_q.msg_length, out_q.msg_offset, out_q.tag_length,
                          out_q.tag_offset, out_q.timestamp_ms, out_q.parse_depth,
                          out_q.level_char};

endmodule

// File: src/llfp_checker.sv
// Port-level checks on the descriptor stream of the log line field parser, with bind.
`include "log_line_field_parser_top_macros.svh"

module llfp_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [llfp_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  `LLFP_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result item changed while stalled")
  `LLFP_ASSERT_NOW(a_raw_level, m_axis_tvalid && m_axis_tdata[9:8] == llfp_pkg::DEPTH_RAW, m_axis_tdata[7:0] == llfp_pkg::CH_QMARK, "raw parse without unknown level")
  `LLFP_ASSERT_NOW(a_ts_zero, m_axis_tvalid && (m_axis_tdata[9:8] == llfp_pkg::DEPTH_RAW || m_axis_tdata[9:8] == llfp_pkg::DEPTH_LEVEL), m_axis_tdata[41:10] == 32'd0, "timestamp set without closing paren")
  `LLFP_ASSERT_NOW(a_tag_zero, m_axis_tvalid && m_axis_tdata[9:8] != llfp_pkg::DEPTH_FULL, m_axis_tdata[65:42] == 24'd0 && m_axis_tdata[79:75] == 5'd0, "tag or message offset set below full parse")

endmodule

bind log_line_field_parser_top llfp_checker u_llfp_checker (.*);

// File: test/tb_log_line_field_parser_top.sv
// Self-checking testbench for the log line field parser top level.
`timescale 1ns / 100ps

module tb_log_line_field_parser_top;
  import llfp_pkg::*;

  localparam logic [9:0] NOT_SEEN    = '1;
  localparam int         STALL_LIMIT = 300;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   s_axis_tlast  = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  log_line_field_parser_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // Tracks the line being scanned and the descriptors still owed by the block.
  class line_desc_checker;
    desc_t       awaited[$];
    int unsigned errors;

    logic [8:0]  position;
    logic        ended;
    logic [7:0]  lead_char;
    logic        hdr_ok;
    logic [7:0]  prev_char;
    logic [9:0]  paren_at;
    logic [9:0]  colon_at;
    num_phase_e  phase;
    logic [31:0] value;
    logic        negative;
    logic        overflow;
    logic [8:0]  crlf_count;
    logic [8:0]  crlf_count_clip;

    function new();
      errors = 0;
      clear_line();
    endfunction

    function void clear_line();
      position        = '0;
      ended           = 1'b0;
      lead_char       = '0;
      hdr_ok          = 1'b0;
      prev_char       = '0;
      paren_at        = NOT_SEEN;
      colon_at        = NOT_SEEN;
      phase           = NUM_SKIP;
      value           = '0;
      negative        = 1'b0;
      overflow        = 1'b0;
      crlf_count      = '0;
      crlf_count_clip = '0;
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function bit is_blank(logic [7:0] c);
      return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    // strtoul-style accumulation, saturating on overflow
    function void advance_number(logic [7:0] c);
      logic [35:0] wide;
      if (phase == NUM_SKIP) begin
        if (is_blank(c)) return;
        if (c == CH_PLUS) begin
          phase = NUM_SIGN;
          return;
        end
        if (c == CH_MINUS) begin
          negative = 1'b1;
          phase    = NUM_SIGN;
          return;
        end
      end
      if (phase == NUM_SKIP || phase == NUM_SIGN) begin
        if (is_digit(c)) begin
          value = 32'(c - CH_ZERO);
          phase = NUM_DIGITS;
        end else begin
          phase = NUM_DONE;
        end
        return;
      end
      if (phase == NUM_DIGITS) begin
        if (!is_digit(c)) begin
          phase = NUM_DONE;
          return;
        end
        if (!overflow) begin
          wide = {4'd0, value} * 36'd10 + 36'(c - CH_ZERO);
          if (wide > 36'hFFFF_FFFF) overflow = 1'b1;
          else value = wide[31:0];
        end
      end
    endfunction

    function void take_char(logic [7:0] c);
      int p;
      p = position;
      if (p == 0) lead_char = c;
      else if (p == 1) hdr_ok = (c == CH_SPACE);
      else if (p == 2) hdr_ok = hdr_ok && (c == CH_LPAREN);
      if (p >= 3) advance_number(c);
      if (p >= 4 && paren_at == NOT_SEEN && prev_char == CH_RPAREN && c == CH_SPACE)
        paren_at = 10'(p - 1);
      else if (paren_at != NOT_SEEN && colon_at == NOT_SEEN && prev_char == CH_COLON &&
               c == CH_SPACE && p - 1 >= int'(paren_at) + 2)
        colon_at = 10'(p - 1);
      crlf_count = (c == CH_CR || c == CH_LF) ? crlf_count + 9'd1 : 9'd0;
      if (p == int'(MSG_MAX_DEF) - 2) crlf_count_clip = crlf_count;
      prev_char = c;
      position  = 9'(p + 1);
    endfunction

    function desc_t close_line();
      desc_t      d;
      int         len, tag_off, tag_len, msg_off, msg_len, run;
      logic [7:0] lvl;
      logic [1:0] depth;
      d   = '0;
      len = position;
      lvl = lead_char;
      if (len < int'(MIN_HEADER_LEN) || !hdr_ok || !(lvl inside {CH_E, CH_W, CH_I, CH_D, CH_V}))
        depth = DEPTH_RAW;
      else if (paren_at == NOT_SEEN) depth = DEPTH_LEVEL;
      else if (colon_at == NOT_SEEN) depth = DEPTH_TIME;
      else depth = DEPTH_FULL;
      if (depth == DEPTH_RAW) lvl = CH_QMARK;
      if (depth == DEPTH_TIME || depth == DEPTH_FULL)
        d.timestamp_ms = overflow ? 32'hFFFF_FFFF : (negative ? 32'd0 - value : value);
      if (depth == DEPTH_FULL) begin
        tag_off = int'(paren_at) + 2;
        tag_len = int'(colon_at) - tag_off;
        if (tag_len > int'(TAG_MAX_DEF) - 1) tag_len = int'(TAG_MAX_DEF) - 1;
        msg_off = int'(colon_at) + 2;
        msg_len = len - msg_off;
        run     = crlf_count < msg_len ? int'(crlf_count) : msg_len;
        msg_len -= run;
        if (msg_len > int'(MSG_MAX_DEF) - 1) msg_len = int'(MSG_MAX_DEF) - 1;
        d.tag_offset = 9'(tag_off);
        d.tag_length = 6'(tag_len);
        d.msg_offset = 9'(msg_off);
      end else begin
        // whole line, cut at the message limit, less the CR/LF run ending the kept part
        if (len <= int'(MSG_MAX_DEF) - 1) begin
          msg_len = len;
          run     = crlf_count;
        end else begin
          msg_len = int'(MSG_MAX_DEF) - 1;
          run     = crlf_count_clip;
        end
        if (run > msg_len) run = msg_len;
        msg_len -= run;
      end
      d.level_char  = lvl;
      d.parse_depth = depth;
      d.msg_length  = 9'(msg_len);
      return d;
    endfunction

    function void note_byte(logic [7:0] c, logic last);
      if (!ended) begin
        if (c == CH_NUL) ended = 1'b1;
        else if (position < LINE_MAX_DEF - 1) take_char(c);
      end
      if (last) begin
        awaited.push_back(close_line());
        clear_line();
      end
    endfunction

    function void match_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        errors++;
        if (errors <= 10)
          $display("mismatch in %s: expected 0x%0h, actual 0x%0h", name, want, got);
      end
    endfunction

    function void check_desc(logic [OUT_TDATA_W-1:0] data);
      desc_t got, want;
      got = data[$bits(desc_t)-1:0];
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected descriptor 0x%0h", data);
        return;
      end
      want = awaited.pop_front();
      match_field("level_char", want.level_char, got.level_char);
      match_field("parse_depth", want.parse_depth, got.parse_depth);
      match_field("timestamp_ms", want.timestamp_ms, got.timestamp_ms);
      match_field("tag_offset", want.tag_offset, got.tag_offset);
      match_field("tag_length", want.tag_length, got.tag_length);
      match_field("msg_offset", want.msg_offset, got.msg_offset);
      match_field("msg_length", want.msg_length, got.msg_length);
      match_field("tdata padding", 0, data[OUT_TDATA_W-1:$bits(desc_t)]);
    endfunction
  endclass

  line_desc_checker board = new();

  logic [7:0] line_data[$];
  bit         in_quiet;
  bit         out_quiet;
  int         stall_count = 0;

  function automatic void push_byte(logic [7:0] c);
    line_data.push_back(c);
  endfunction

  function automatic void push_text(string s);
    foreach (s[k]) line_data.push_back(s[k]);
  endfunction

  function automatic logic [7:0] printable();
    return 8'($urandom_range(33, 126));
  endfunction

  function automatic logic [7:0] crlf_char();
    return $urandom_range(0, 1) ? CH_CR : CH_LF;
  endfunction

  function automatic logic [7:0] level_letter();
    logic [7:0] letters[5];
    letters = '{CH_E, CH_W, CH_I, CH_D, CH_V};
    return letters[$urandom_range(0, 4)];
  endfunction

  function automatic logic [7:0] msg_char();
    case ($urandom_range(0, 9))
      0:       return 8'($urandom_range(128, 255));
      1:       return crlf_char();
      2:       return CH_SPACE;
      default: return printable();
    endcase
  endfunction

  // whitespace, sign, digits (sometimes enough to saturate), stray byte
  function automatic void push_stamp();
    int nd;
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3))
        push_byte($urandom_range(0, 1) ? CH_SPACE : 8'(CH_TAB + $urandom_range(0, 4)));
    case ($urandom_range(0, 5))
      0:       push_byte(CH_PLUS);
      1:       push_byte(CH_MINUS);
      default: ;
    endcase
    if ($urandom_range(0, 7) == 0) begin
      push_text($urandom_range(0, 1) ? "4294967295" : "4294967296");
    end else begin
      nd = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 13) : $urandom_range(0, 6);
      repeat (nd) push_byte(8'(CH_ZERO + $urandom_range(0, 9)));
    end
    if ($urandom_range(0, 5) == 0) push_byte(printable());
  endfunction

  function automatic void build_entry();
    int n, at;
    push_byte(($urandom_range(0, 7) == 0) ? 8'($urandom_range(1, 255)) : level_letter());
    push_byte(CH_SPACE);
    push_byte(CH_LPAREN);
    push_stamp();
    push_byte(CH_RPAREN);
    push_byte(CH_SPACE);
    n = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 60) : $urandom_range(0, 8);
    repeat (n) push_byte(printable());
    push_byte(CH_COLON);
    push_byte(CH_SPACE);
    repeat ($urandom_range(0, 20)) push_byte(msg_char());
    repeat ($urandom_range(0, 3)) push_byte(crlf_char());
    // break the line now and then
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 3))
        0: begin
          at = $urandom_range(0, (line_data.size() > 8) ? 8 : line_data.size() - 1);
          line_data[at] = 8'($urandom_range(0, 255));
        end
        1: line_data = line_data[0:$urandom_range(0, line_data.size() - 1)];
        2: line_data.insert($urandom_range(0, line_data.size() - 1), CH_NUL);
        default: line_data[$urandom_range(0, line_data.size() - 1)] = 8'($urandom_range(0, 255));
      endcase
    end
  endfunction

  // long_kind 0: full line past the line limit, 1: raw line with CR/LF at the message cut,
  // 2: full line with a message near the message limit
  function automatic void build_long(int long_kind);
    int total;
    if (long_kind == 1) begin
      total = $urandom_range(384, 400);
      repeat (total) push_byte(printable());
      for (int k = int'(MSG_MAX_DEF) - 4; k <= int'(MSG_MAX_DEF) - 2; k++)
        line_data[k] = crlf_char();
      if ($urandom_range(0, 1)) line_data[MSG_MAX_DEF - 1] = crlf_char();
    end else begin
      push_byte(level_letter());
      push_text(" (42) long_tag: ");
      total = (long_kind == 0) ? $urandom_range(512, 540) : $urandom_range(382, 400);
      while (line_data.size() < total) push_byte(msg_char());
      repeat ($urandom_range(1, 3)) push_byte(crlf_char());
    end
  endfunction

  function automatic int draw_wait(bit quiet);
    return quiet ? 0 : $urandom_range(0, 12);
  endfunction

  task automatic send_byte(input logic [7:0] c, input logic last);
    int gap;
    gap = draw_wait(in_quiet);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_byte(c, last);
  endtask

  task automatic send_line();
    if (line_data.size() == 0) push_byte(printable());
    in_quiet = ($urandom_range(0, 3) == 0);
    foreach (line_data[k]) send_byte(line_data[k], k == line_data.size() - 1);
    line_data.delete();
  endtask

  task automatic take_desc();
    int gap;
    gap = draw_wait(out_quiet);
    if (gap > 0) begin
      m_axis_tready <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    m_axis_tready <= 1'b1;
    do @(posedge clk_i); while (!m_axis_tvalid);
    board.check_desc(m_axis_tdata);
    if ($urandom_range(0, 3) == 0) out_quiet = !out_quiet;
  endtask

  initial begin
    @(posedge rst_ni);
    forever take_desc();
  end

  // end the run when nothing moves on either side for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_count <= 0;
    end else if (stall_count == STALL_LIMIT) begin
      $display("tb_log_line_field_parser_top failed");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  initial begin
    int sent;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty line, then a lone byte with the top bit set
    push_byte(CH_NUL);
    send_line();
    push_byte(8'hFF);
    send_line();
    // negative stamp wraps, one-byte tag, message stripped to nothing
    push_text("D (-1) a: ");
    push_byte(CH_LF);
    send_line();
    // stamp without tag, and a zero byte ends the text early
    push_text("V (7) q");
    push_byte(CH_NUL);
    push_text("z");
    send_line();

    sent = 0;
    for (int n = 0; sent < 450 || n < 40; n++) begin
      if (n == 6) build_long(0);
      else if (n == 18) build_long(1);
      else if (n == 30) build_long(2);
      else if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 24))
        push_byte(8'($urandom_range(0, 255)));
      else build_entry();
      sent += line_data.size();
      send_line();
    end
    s_axis_tvalid <= 1'b0;
    s_axis_tlast  <= 1'b0;

    while (board.awaited.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (board.errors == 0 && board.awaited.size() == 0) begin
      $display("tb_log_line_field_parser_top passed");
    end else begin
      $display("tb_log_line_field_parser_top failed");
    end
    $finish;
  end

endmodule
